### rtl/core/gray_gamma_tint_pixel_defines.svh
// Assertion macros shared by the gray, gamma and tint pixel RTL.
// Files that assert include this header; it depends on nothing else.
`ifndef GRAY_GAMMA_TINT_PIXEL_DEFINES_SVH
`define GRAY_GAMMA_TINT_PIXEL_DEFINES_SVH

// Same-cycle implication, checked on clk while rst_n is high.
`define GGT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gray_gamma_tint_pixel assertion failed");

// Next-cycle implication, checked on clk while rst_n is high.
`define GGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gray_gamma_tint_pixel assertion failed");

`endif

### rtl/core/ggt_pkg.sv
// Package for the gray, gamma and tint pixel pipeline: widths, weights,
// register codes, stage structs and the exp2 root constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ggt_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LUMA_W  = 24;
  localparam int unsigned GAMMA_W = 16;
  localparam int unsigned TINT_W  = 17;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned LOG_W   = EXP_W + FRAC_W;
  localparam int unsigned MANT_W  = 32;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [15:0] W_RED   = 16'd19661;
  localparam logic [15:0] W_GREEN = 16'd38666;
  localparam logic [15:0] W_BLUE  = 16'd7209;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET  = 16'd5734;
  localparam logic [TINT_W-1:0]  TINT_B_RESET = 17'd49152;
  localparam logic [TINT_W-1:0]  TINT_G_RESET = 17'd0;
  localparam logic [TINT_W-1:0]  TINT_R_RESET = 17'd0;

  localparam logic [PIX_W-1:0] MAX_CODE = 8'd255;

  typedef enum logic [1:0] {
    REG_GAMMA  = 2'd0,
    REG_TINT_B = 2'd1,
    REG_TINT_G = 2'd2,
    REG_TINT_R = 2'd3
  } ggt_reg_t;

  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [LOG_W-1:0]  lg;
  } ggt_log_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] gray;
  } ggt_gray_t;

  function automatic logic [63:0] ggt_isqrt(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root i is 2^(2^-i) in Q2.30, each the truncated square root of the one before.
  function automatic logic [ACC_W-1:0] ggt_root(input int unsigned i);
    logic [63:0] v;
    v = 64'd1 << 31;
    for (int unsigned j = 1; j <= FRAC_W; j++) begin
      if (j <= i) begin
        v = ggt_isqrt(v << 30);
      end
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/ggt_log2.sv
// Pipelined fixed-point log2 of the Q8.16 luma: one normalize stage, then one
// squaring stage per fraction bit. Depends on ggt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ggt_log2 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        valid_i,
  input  wire logic [ggt_pkg::LUMA_W-1:0]  luma_i,
  output ggt_pkg::ggt_log_t                log_o
);

  localparam int unsigned N = ggt_pkg::FRAC_W;

  logic [ggt_pkg::MANT_W-1:0] m_r    [0:N];
  logic [ggt_pkg::FRAC_W-1:0] frac_r [0:N];
  logic [ggt_pkg::EXP_W-1:0]  e_r    [0:N];
  logic                       zero_r [0:N];
  logic                       v_r    [0:N];

  logic [ggt_pkg::EXP_W-1:0]  e_nxt;
  logic [ggt_pkg::MANT_W-1:0] m_nxt;

  always_comb begin
    e_nxt = '0;
    for (int j = 0; j < ggt_pkg::LUMA_W; j++) begin
      if (luma_i[j]) begin
        e_nxt = ggt_pkg::EXP_W'(j);
      end
    end
    m_nxt = {{(ggt_pkg::MANT_W - ggt_pkg::LUMA_W){1'b0}}, luma_i}
            << (5'd31 - e_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
    m_r[0]    <= m_nxt;
    frac_r[0] <= '0;
    e_r[0]    <= e_nxt;
    zero_r[0] <= (luma_i == '0);
  end

  for (genvar s = 0; s < N; s++) begin : g_sq
    logic [63:0] sq_full;
    logic [32:0] sq;
    assign sq_full = 64'(m_r[s]) * 64'(m_r[s]);
    assign sq      = sq_full[63:31];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
      if (sq[32]) begin
        m_r[s+1] <= sq[32:1];
      end else begin
        m_r[s+1] <= sq[31:0];
      end
      frac_r[s+1] <= {frac_r[s][ggt_pkg::FRAC_W-2:0], sq[32]};
      e_r[s+1]    <= e_r[s];
      zero_r[s+1] <= zero_r[s];
    end
  end

  assign log_o.valid = v_r[N];
  assign log_o.zero  = zero_r[N];
  assign log_o.lg    = $signed({e_r[N] - 5'd16, frac_r[N]});

endmodule

`default_nettype wire

### rtl/core/ggt_exp2.sv
// Pipelined gamma multiply and fixed-point exp2 with saturation to a gray
// code: product, classify, one stage per fraction bit, final shift. Uses ggt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ggt_exp2 (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  ggt_pkg::ggt_log_t                 log_i,
  input  wire logic [ggt_pkg::GAMMA_W-1:0]  gamma_i,
  output ggt_pkg::ggt_gray_t                gray_o
);

  localparam int unsigned N      = ggt_pkg::FRAC_W;
  localparam int unsigned PROD_W = ggt_pkg::LOG_W + ggt_pkg::GAMMA_W + 1;

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     pzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= log_i.valid;
    end
    prod_r  <= PROD_W'(log_i.lg) * $signed(PROD_W'({1'b0, gamma_i}));
    pzero_r <= log_i.zero;
  end

  logic [ggt_pkg::ACC_W-1:0]  acc_r  [0:N];
  logic [ggt_pkg::FRAC_W-1:0] f_r    [0:N];
  logic [2:0]                 k_r    [0:N];
  logic                       low_r  [0:N];
  logic                       sat_r  [0:N];
  logic                       v_r    [0:N];

  logic neg_c;
  logic sat_c;
  assign neg_c = prod_r[PROD_W-1];
  assign sat_c = !neg_c && (prod_r[PROD_W-2:39] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= pv_r;
    end
    acc_r[0] <= ggt_pkg::ACC_W'(64'd1 << 30);
    f_r[0]   <= prod_r[35:12];
    k_r[0]   <= prod_r[38:36];
    low_r[0] <= pzero_r || neg_c;
    sat_r[0] <= sat_c;
  end

  for (genvar s = 0; s < N; s++) begin : g_mul
    localparam logic [ggt_pkg::ACC_W-1:0] ROOT = ggt_pkg::ggt_root(s + 1);
    logic [63:0] pr;
    assign pr = 64'(acc_r[s]) * 64'(ROOT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
      if (f_r[s][N-1-s]) begin
        acc_r[s+1] <= pr[61:30];
      end else begin
        acc_r[s+1] <= acc_r[s];
      end
      f_r[s+1]   <= f_r[s];
      k_r[s+1]   <= k_r[s];
      low_r[s+1] <= low_r[s];
      sat_r[s+1] <= sat_r[s];
    end
  end

  logic [38:0]              shifted;
  logic [8:0]               whole;
  logic [ggt_pkg::PIX_W-1:0] gray_nxt;
  logic [ggt_pkg::PIX_W-1:0] gray_r;
  logic                      gv_r;

  always_comb begin
    shifted = 39'(acc_r[N]) << k_r[N];
    whole   = shifted[38:30];
    if (low_r[N]) begin
      gray_nxt = '0;
    end else if (sat_r[N] || whole[8]) begin
      gray_nxt = ggt_pkg::MAX_CODE;
    end else begin
      gray_nxt = whole[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= 1'b0;
    end else begin
      gv_r <= v_r[N];
    end
    gray_r <= gray_nxt;
  end

  assign gray_o.valid = gv_r;
  assign gray_o.gray  = gray_r;

endmodule

`default_nettype wire

### rtl/core/gray_gamma_tint_pixel.sv
// A pixel transfer is taken whenever start is high outside reset, one per clock,
// and its tinted gray result appears on out_blue, out_green and out_red with
// out_valid high for one cycle; the receiver cannot stall. The pipeline holds
// the 24 squaring stages of the log2 and the 24 multiply stages of the exp2,
// plus six further register stages. Registers are written over the APB-style
// port.
`timescale 1ns / 1ps
`default_nettype none
`include "gray_gamma_tint_pixel_defines.svh"

module gray_gamma_tint_pixel (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [ggt_pkg::PIX_W-1:0]   in_blue,
  input  wire logic [ggt_pkg::PIX_W-1:0]   in_green,
  input  wire logic [ggt_pkg::PIX_W-1:0]   in_red,
  output      logic                        out_valid,
  output      logic [ggt_pkg::PIX_W-1:0]   out_blue,
  output      logic [ggt_pkg::PIX_W-1:0]   out_green,
  output      logic [ggt_pkg::PIX_W-1:0]   out_red,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ggt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ggt_pkg::DATA_W-1:0]  pwdata,
  output      logic [ggt_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready
);

  logic [ggt_pkg::GAMMA_W-1:0] gamma_r;
  logic [ggt_pkg::TINT_W-1:0]  tint_b_r;
  logic [ggt_pkg::TINT_W-1:0]  tint_g_r;
  logic [ggt_pkg::TINT_W-1:0]  tint_r_r;
  ggt_pkg::ggt_reg_t           reg_sel;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign busy    = !rst_n;
  assign reg_sel = ggt_pkg::ggt_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= ggt_pkg::GAMMA_RESET;
      tint_b_r <= ggt_pkg::TINT_B_RESET;
      tint_g_r <= ggt_pkg::TINT_G_RESET;
      tint_r_r <= ggt_pkg::TINT_R_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        ggt_pkg::REG_GAMMA:  gamma_r  <= pwdata[ggt_pkg::GAMMA_W-1:0];
        ggt_pkg::REG_TINT_B: tint_b_r <= pwdata[ggt_pkg::TINT_W-1:0];
        ggt_pkg::REG_TINT_G: tint_g_r <= pwdata[ggt_pkg::TINT_W-1:0];
        ggt_pkg::REG_TINT_R: tint_r_r <= pwdata[ggt_pkg::TINT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ggt_pkg::REG_GAMMA:  prdata = 32'(gamma_r);
      ggt_pkg::REG_TINT_B: prdata = 32'(tint_b_r);
      ggt_pkg::REG_TINT_G: prdata = 32'(tint_g_r);
      ggt_pkg::REG_TINT_R: prdata = 32'(tint_r_r);
      default:             prdata = '0;
    endcase
  end

  logic [ggt_pkg::LUMA_W-1:0] luma_r;
  logic                       lv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else begin
      lv_r <= start && !busy;
    end
    luma_r <= ggt_pkg::LUMA_W'(in_red) * ggt_pkg::LUMA_W'(ggt_pkg::W_RED)
            + ggt_pkg::LUMA_W'(in_green) * ggt_pkg::LUMA_W'(ggt_pkg::W_GREEN)
            + ggt_pkg::LUMA_W'(in_blue) * ggt_pkg::LUMA_W'(ggt_pkg::W_BLUE);
  end

  ggt_pkg::ggt_log_t  log_s;
  ggt_pkg::ggt_gray_t gray_s;

  ggt_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (lv_r),
    .luma_i  (luma_r),
    .log_o   (log_s)
  );

  ggt_exp2 u_exp2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .log_i   (log_s),
    .gamma_i (gamma_r),
    .gray_o  (gray_s)
  );

  function automatic logic [ggt_pkg::PIX_W-1:0] tint_ch(
    input logic [ggt_pkg::PIX_W-1:0]  gray,
    input logic [ggt_pkg::TINT_W-1:0] t
  );
    logic [ggt_pkg::PIX_W-1:0] diff;
    logic [24:0]               pr;
    logic [9:0]                sum;
    diff = ggt_pkg::MAX_CODE - gray;
    pr   = 25'(diff) * 25'(t);
    sum  = 10'(gray) + 10'(pr[24:16]);
    return (sum > 10'(ggt_pkg::MAX_CODE)) ? ggt_pkg::MAX_CODE : sum[7:0];
  endfunction

  logic                      ov_r;
  logic [ggt_pkg::PIX_W-1:0] ob_r;
  logic [ggt_pkg::PIX_W-1:0] og_r;
  logic [ggt_pkg::PIX_W-1:0] or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= gray_s.valid;
    end
    ob_r <= tint_ch(gray_s.gray, tint_b_r);
    og_r <= tint_ch(gray_s.gray, tint_g_r);
    or_r <= tint_ch(gray_s.gray, tint_r_r);
  end

  assign out_valid = ov_r;
  assign out_blue  = ob_r;
  assign out_green = og_r;
  assign out_red   = or_r;

  `GGT_ASSERT_NEXT(a_gray_to_out, gray_s.valid, out_valid)
  `GGT_ASSERT_IMPL(a_out_from_gray, out_valid, $past(gray_s.valid))
  `GGT_ASSERT_IMPL(a_tint_not_below, out_valid,
    (out_blue >= $past(gray_s.gray)) && (out_green >= $past(gray_s.gray))
    && (out_red >= $past(gray_s.gray)))
  `GGT_ASSERT_IMPL(a_sat_white, out_valid && ($past(gray_s.gray) == ggt_pkg::MAX_CODE),
    (out_blue == ggt_pkg::MAX_CODE) && (out_green == ggt_pkg::MAX_CODE)
    && (out_red == ggt_pkg::MAX_CODE))

endmodule

`default_nettype wire
